// ===== src/bscs_pkg.sv =====
// shared constants, types and command codes for the background subtract block
package bscs_pkg;

   localparam int ROWS = 512;
   localparam int COLS = 512;
   localparam int DEPTH = ROWS * COLS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam int ADDR_W = 18;
   localparam int PIX_W = 8;
   localparam int COORD_W = 9;
   localparam int ADJ_W = 9;
   localparam int SUM_W = 10;

   localparam int QDEPTH = 4;
   localparam int QW = $clog2(QDEPTH);

   localparam logic signed [SUM_W-1:0] AVG_BIAS = 10'sd128;
   localparam logic [7:0] FULL_SCALE = 8'd255;

   localparam logic CSR_BLACK_LEVEL = 1'b0;
   localparam logic CSR_WHITE_LEVEL = 1'b1;

   typedef enum logic [1:0] {
      OP_PIXEL   = 2'd0,
      OP_ARM_SUB = 2'd1,
      OP_ARM_AVG = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef struct packed {
      logic [ADDR_W-1:0]       address;
      logic signed [SUM_W-1:0] sum;
   } entry_type;

endpackage

// ===== src/bscs_front.sv =====
// front part: accepts items, tracks captures, owns the background store
module bscs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic                          req_frame_start,
   input  logic [bscs_pkg::COORD_W-1:0]  req_row,
   input  logic [bscs_pkg::COORD_W-1:0]  req_col,
   input  logic [bscs_pkg::PIX_W-1:0]    req_pixel,
   input  logic                          queue_full,
   output logic                          push,
   output bscs_pkg::entry_type           push_entry
);

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                        state_ff;
   logic [bscs_pkg::AW-1:0]          sweep_ff;
   logic                             sub_pend_ff, avg_pend_ff, sub_act_ff, avg_act_ff;
   logic                             sub_pend_in, avg_pend_in, sub_act_in, avg_act_in;
   logic [bscs_pkg::ADDR_W-1:0]      addr_ff;
   logic [bscs_pkg::PIX_W-1:0]       pix_ff;
   logic signed [bscs_pkg::ADJ_W-1:0] rd_data_ff;

   logic signed [bscs_pkg::ADJ_W-1:0] mem [bscs_pkg::DEPTH];

   bscs_pkg::op_type                 op;
   logic                             accept, is_pixel, in_range, capture;
   logic [31:0]                      flat;
   logic [bscs_pkg::AW-1:0]          mem_addr, wr_addr;
   logic                             wr_en;
   logic signed [bscs_pkg::ADJ_W-1:0] wr_data;
   logic signed [bscs_pkg::SUM_W-1:0] pix_s, cap_wide, cap_sum, rd_sum;
   logic signed [bscs_pkg::ADJ_W-1:0] cap;

   assign op = bscs_pkg::op_type'(req_operation);
   assign req_stall = (state_ff != ST_IDLE) || queue_full;
   assign accept = req_valid && !req_stall;
   assign is_pixel = (op == bscs_pkg::OP_PIXEL);
   assign in_range = (32'(req_row) < 32'(bscs_pkg::ROWS)) &&
                     (32'(req_col) < 32'(bscs_pkg::COLS));
   assign flat = (32'(bscs_pkg::ROWS - 1) - 32'(req_row)) * 32'(bscs_pkg::COLS)
                 + 32'(req_col);
   assign mem_addr = flat[bscs_pkg::AW-1:0];

   always_comb begin
      sub_pend_in = sub_pend_ff;
      avg_pend_in = avg_pend_ff;
      sub_act_in = sub_act_ff;
      avg_act_in = avg_act_ff;
      if (accept) begin
         unique case (op)
            bscs_pkg::OP_ARM_SUB: sub_pend_in = 1'b1;
            bscs_pkg::OP_ARM_AVG: avg_pend_in = 1'b1;
            bscs_pkg::OP_CLEAR: ;
            bscs_pkg::OP_PIXEL: begin
               if (req_frame_start) begin
                  sub_act_in = sub_pend_ff;
                  avg_act_in = avg_pend_ff;
                  sub_pend_in = 1'b0;
                  avg_pend_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign capture = sub_act_in || avg_act_in;
   assign pix_s = $signed({2'b00, req_pixel});
   assign cap_wide = avg_act_in ? (bscs_pkg::AVG_BIAS - pix_s) : -pix_s;
   assign cap = cap_wide[bscs_pkg::ADJ_W-1:0];
   assign cap_sum = pix_s + $signed({cap[bscs_pkg::ADJ_W-1], cap});
   assign rd_sum = $signed({2'b00, pix_ff}) +
                   $signed({rd_data_ff[bscs_pkg::ADJ_W-1], rd_data_ff});

   always_comb begin
      wr_en = 1'b0;
      wr_addr = mem_addr;
      wr_data = cap;
      if (state_ff == ST_SWEEP) begin
         wr_en = 1'b1;
         wr_addr = sweep_ff;
         wr_data = '0;
      end else if (accept && is_pixel && in_range && capture) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_comb begin
      push = 1'b0;
      push_entry.address = flat[bscs_pkg::ADDR_W-1:0];
      push_entry.sum = cap_sum;
      if (state_ff == ST_READ) begin
         push = 1'b1;
         push_entry.address = addr_ff;
         push_entry.sum = rd_sum;
      end else if (accept && is_pixel && in_range && capture) begin
         push = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         sweep_ff <= '0;
         sub_pend_ff <= 1'b0;
         avg_pend_ff <= 1'b0;
         sub_act_ff <= 1'b0;
         avg_act_ff <= 1'b0;
      end else begin
         sub_pend_ff <= sub_pend_in;
         avg_pend_ff <= avg_pend_in;
         sub_act_ff <= sub_act_in;
         avg_act_ff <= avg_act_in;
         unique case (state_ff)
            ST_SWEEP: begin
               if (32'(sweep_ff) == 32'(bscs_pkg::DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
                  sweep_ff <= '0;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (accept && op == bscs_pkg::OP_CLEAR) begin
                  state_ff <= ST_SWEEP;
                  sweep_ff <= '0;
               end else if (accept && is_pixel && in_range && !capture) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= flat[bscs_pkg::ADDR_W-1:0];
         pix_ff <= req_pixel;
      end
   end

endmodule

// ===== src/bscs_queue.sv =====
// short queue of adjusted pixels between the front and back parts
module bscs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bscs_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output bscs_pkg::entry_type head
);

   bscs_pkg::entry_type        slots [bscs_pkg::QDEPTH];
   logic [bscs_pkg::QW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [bscs_pkg::QW:0]      count_ff;
   logic                       do_push, do_pop;

   assign full = (32'(count_ff) == bscs_pkg::QDEPTH);
   assign not_empty = (count_ff != '0);
   assign head = slots[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/bscs_back.sv =====
// back part: window/level stretch by restoring division and output register
module bscs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  bscs_pkg::entry_type          q_entry,
   output logic                         q_pop,
   input  logic [7:0]                   black_level,
   input  logic [7:0]                   white_level,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bscs_pkg::ADDR_W-1:0]  rsp_out_address,
   output logic [7:0]                   rsp_gray_level
);

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_CHK,
      B_DIV,
      B_DONE
   } state_type;

   state_type                    state_ff;
   logic [bscs_pkg::ADDR_W-1:0]  addr_ff;
   logic signed [10:0]           diff_ff;
   logic [16:0]                  rem_ff;
   logic [7:0]                   span_ff, quot_ff;
   logic [2:0]                   bit_ff;
   logic                         rsp_valid_ff;
   logic [bscs_pkg::ADDR_W-1:0]  rsp_addr_ff;
   logic [7:0]                   rsp_gray_ff;

   logic [7:0]                   span;
   logic [16:0]                  product, divisor, limit;
   logic                         out_free;

   assign span = (white_level > black_level) ? (white_level - black_level) : 8'd1;
   assign product = 17'(diff_ff[8:0]) * 17'(bscs_pkg::FULL_SCALE);
   assign divisor = 17'(span_ff) << bit_ff;
   assign limit = {1'b0, span_ff, 8'd0};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop = (state_ff == B_IDLE) && q_valid;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_address = rsp_addr_ff;
   assign rsp_gray_level = rsp_gray_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == B_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (q_valid) begin
                  addr_ff <= q_entry.address;
                  diff_ff <= 11'(q_entry.sum) - $signed({3'b000, black_level});
                  span_ff <= span;
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               quot_ff <= '0;
               if (diff_ff <= 11'sd0) begin
                  state_ff <= B_DONE;
               end else begin
                  rem_ff <= product;
                  state_ff <= B_CHK;
               end
            end
            B_CHK: begin
               bit_ff <= 3'd7;
               if (rem_ff >= limit) begin
                  quot_ff <= bscs_pkg::FULL_SCALE;
                  state_ff <= B_DONE;
               end else begin
                  state_ff <= B_DIV;
               end
            end
            B_DIV: begin
               if (rem_ff >= divisor) begin
                  rem_ff <= rem_ff - divisor;
                  quot_ff[bit_ff] <= 1'b1;
               end
               if (bit_ff == 3'd0) begin
                  state_ff <= B_DONE;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            B_DONE: begin
               if (out_free) begin
                  rsp_addr_ff <= addr_ff;
                  rsp_gray_ff <= quot_ff;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// ===== src/background_subtract_contrast_stretch.sv =====
// top level: background subtraction with window/level contrast stretch
// usage:
//   req_* carries one item per accept (valid high, stall low): a pixel with
//   row, col and frame-start mark, or a command (arm subtract, arm average,
//   clear store). arm commands take effect at the next frame-start pixel.
//   rsp_* gives one item per in-range pixel: row-flipped address and the
//   stretched gray level. commands and out-of-range pixels give none.
//   csr_* writes the black level (index 0) and white level (index 1) while idle.
// processing:
//   the front pushes a capturing in-range pixel at accept; any other in-range
//   pixel goes through a store read state before its push, with req_stall high.
//   the back works on one pixel at a time: load, multiply, range check, 8
//   restoring divide steps and output load; fewer steps when the level is at
//   or below the black level or saturates. it takes the next pixel from the
//   queue only when idle. a 4-entry queue decouples the two parts.
// reset and clear:
//   after reset, and after each clear command, the store is zeroed by a sweep
//   over all ROWS*COLS entries (262144) while req_stall stays high.
//   a stalled result holds in the output register; the back keeps working
//   on the next item and the front keeps filling the queue.
module background_subtract_contrast_stretch (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic                          req_frame_start,
   input  logic [bscs_pkg::COORD_W-1:0]  req_row,
   input  logic [bscs_pkg::COORD_W-1:0]  req_col,
   input  logic [bscs_pkg::PIX_W-1:0]    req_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bscs_pkg::ADDR_W-1:0]   rsp_out_address,
   output logic [7:0]                    rsp_gray_level,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [7:0]                    csr_write_data
);

   logic [7:0]           black_level_ff, white_level_ff;
   logic                 push, full, pop, not_empty;
   bscs_pkg::entry_type  push_entry, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         black_level_ff <= 8'd0;
         white_level_ff <= 8'd255;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bscs_pkg::CSR_BLACK_LEVEL: black_level_ff <= csr_write_data;
            bscs_pkg::CSR_WHITE_LEVEL: white_level_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   bscs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_frame_start (req_frame_start),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_pixel       (req_pixel),
      .queue_full      (full),
      .push            (push),
      .push_entry      (push_entry)
   );

   bscs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   bscs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (not_empty),
      .q_entry         (head),
      .q_pop           (pop),
      .black_level     (black_level_ff),
      .white_level     (white_level_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_address (rsp_out_address),
      .rsp_gray_level  (rsp_gray_level)
   );

endmodule

// ===== src/bscs_checker.sv =====
// port-level checker for the background subtract block and its bind
module bscs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bscs_pkg::ADDR_W-1:0]   rsp_out_address,
   input logic [7:0]                    rsp_gray_level
);

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input not held off during store sweep after reset");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_operation == bscs_pkg::OP_CLEAR) |=> req_stall)
      else $error("input not held off after clear command");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_address) && $stable(rsp_gray_level)))
      else $error("stalled result changed");

   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(!rsp_stall))
      else $error("result dropped without being taken");

endmodule

bind background_subtract_contrast_stretch bscs_checker u_bscs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_operation   (req_operation),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_address (rsp_out_address),
   .rsp_gray_level  (rsp_gray_level)
);

// ===== tb/sv/background_subtract_contrast_stretch_test.sv =====
// testbench for background_subtract_contrast_stretch: directed and random pixel streams checked by a scoreboard
`timescale 1ns / 1ps

module background_subtract_contrast_stretch_test;

   class stretch_scoreboard;
      int                   errors;
      logic [7:0]           black_lvl;
      logic [7:0]           white_lvl;
      int                   background[int];
      bit                   sub_armed, avg_armed, sub_live, avg_live;
      logic [bscs_pkg::ADDR_W-1:0] want_address[$];
      logic [7:0]           want_gray[$];

      function new();
         errors = 0;
         black_lvl = 8'd0;
         white_lvl = 8'd255;
      endfunction

      function int pending();
         return want_address.size();
      endfunction

      function void note_item(bscs_pkg::op_type op, bit fs, int row, int col, int pix);
         int addr, adj, span, num, q;
         unique case (op)
            bscs_pkg::OP_ARM_SUB: begin
               sub_armed = 1;
               return;
            end
            bscs_pkg::OP_ARM_AVG: begin
               avg_armed = 1;
               return;
            end
            bscs_pkg::OP_CLEAR: begin
               background.delete();
               return;
            end
            default: ;
         endcase
         if (fs) begin
            sub_live = sub_armed;
            avg_live = avg_armed;
            sub_armed = 0;
            avg_armed = 0;
         end
         if (row >= bscs_pkg::ROWS || col >= bscs_pkg::COLS) return;
         addr = (bscs_pkg::ROWS - 1 - row) * bscs_pkg::COLS + col;
         if (avg_live) background[addr] = 128 - pix;
         else if (sub_live) background[addr] = -pix;
         adj = background.exists(addr) ? background[addr] : 0;
         span = (white_lvl > black_lvl) ? int'(white_lvl) - int'(black_lvl) : 1;
         num = (pix + adj - int'(black_lvl)) * 255;
         q = (num < 0) ? 0 : num / span;
         if (q > 255) q = 255;
         want_address.push_back(addr[bscs_pkg::ADDR_W-1:0]);
         want_gray.push_back(q[7:0]);
      endfunction

      function void check_result(logic [bscs_pkg::ADDR_W-1:0] address, logic [7:0] gray);
         logic [bscs_pkg::ADDR_W-1:0] ea;
         logic [7:0]        eg;
         if (want_address.size() == 0) begin
            $display("%0t: unexpected item address %0d gray %0d", $time, address, gray);
            errors++;
            return;
         end
         ea = want_address.pop_front();
         eg = want_gray.pop_front();
         if (ea !== address) begin
            $display("%0t: out_address expected %0d actual %0d", $time, ea, address);
            errors++;
         end
         if (eg !== gray) begin
            $display("%0t: gray_level expected %0d actual %0d", $time, eg, gray);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_operation;
   logic                 req_frame_start;
   logic [bscs_pkg::COORD_W-1:0] req_row;
   logic [bscs_pkg::COORD_W-1:0] req_col;
   logic [bscs_pkg::PIX_W-1:0]   req_pixel;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [bscs_pkg::ADDR_W-1:0]  rsp_out_address;
   logic [7:0]           rsp_gray_level;
   logic                 csr_write_enable;
   logic                 csr_index;
   logic [7:0]           csr_write_data;

   stretch_scoreboard sb = new();
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_left = 0;

   background_subtract_contrast_stretch u_top (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(1, 40);
      end
      stall_left--;
      unique case (stall_mode)
         0: rsp_stall = 1'b0;
         1: rsp_stall = 1'($urandom_range(0, 1));
         default: rsp_stall = ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_out_address, rsp_gray_level);
   end

   // watchdog on cycles with no handshake, such as during a clear sweep
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 1000000) begin
         $display("FAIL background_subtract_contrast_stretch");
         $finish;
      end
   end

   task automatic send(bscs_pkg::op_type op, int fs, int row, int col, int pix);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_operation = op;
      req_frame_start = fs[0];
      req_row = row[bscs_pkg::COORD_W-1:0];
      req_col = col[bscs_pkg::COORD_W-1:0];
      req_pixel = pix[bscs_pkg::PIX_W-1:0];
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_item(op, fs[0], row, col, pix);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic set_clip(logic [7:0] lo, logic [7:0] hi);
      req_valid = 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = bscs_pkg::CSR_BLACK_LEVEL;
      csr_write_data = lo;
      @(negedge clock);
      csr_index = bscs_pkg::CSR_WHITE_LEVEL;
      csr_write_data = hi;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.black_lvl = lo;
      sb.white_lvl = hi;
   endtask

   task automatic random_frames(int count);
      int sent, n, r0, c0;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(0, 9))
            0, 1: send(bscs_pkg::OP_ARM_SUB, $urandom_range(0, 1), $urandom, $urandom,
                       $urandom);
            2, 3: send(bscs_pkg::OP_ARM_AVG, $urandom_range(0, 1), $urandom, $urandom,
                       $urandom);
            4: begin
               send(bscs_pkg::OP_ARM_SUB, 0, 0, 0, 0);
               send(bscs_pkg::OP_ARM_AVG, 0, 0, 0, 0);
            end
            default: ;
         endcase
         n = $urandom_range(2, 16);
         r0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 3);
         c0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 3);
         send(bscs_pkg::OP_PIXEL, 1, r0, c0, $urandom_range(0, 255));
         for (int i = 1; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
               send(bscs_pkg::OP_PIXEL, $urandom_range(0, 1), $urandom_range(0, 511),
                    $urandom_range(0, 511), $urandom_range(0, 255));
            else
               send(bscs_pkg::OP_PIXEL, 0, (r0 + $urandom_range(0, 3)) % 512,
                    (c0 + $urandom_range(0, 3)) % 512, $urandom_range(0, 255));
         end
         sent += n;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = bscs_pkg::OP_PIXEL;
      req_frame_start = 1'b0;
      req_row = '0;
      req_col = '0;
      req_pixel = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = bscs_pkg::CSR_BLACK_LEVEL;
      csr_write_data = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed part
      send(bscs_pkg::OP_PIXEL, 1, 0, 0, 0);
      send(bscs_pkg::OP_PIXEL, 0, 511, 511, 255);
      send(bscs_pkg::OP_ARM_SUB, 1, 511, 511, 255);
      send(bscs_pkg::OP_ARM_SUB, 0, 0, 0, 0);
      send(bscs_pkg::OP_PIXEL, 1, 0, 0, 200);
      send(bscs_pkg::OP_PIXEL, 0, 511, 511, 170);
      send(bscs_pkg::OP_PIXEL, 1, 0, 0, 90);
      send(bscs_pkg::OP_PIXEL, 0, 511, 511, 255);
      send(bscs_pkg::OP_ARM_SUB, 0, 0, 0, 0);
      send(bscs_pkg::OP_ARM_AVG, 0, 0, 0, 0);
      send(bscs_pkg::OP_PIXEL, 1, 0, 0, 10);
      send(bscs_pkg::OP_PIXEL, 0, 1, 2, 255);
      send(bscs_pkg::OP_PIXEL, 1, 0, 0, 50);
      send(bscs_pkg::OP_PIXEL, 0, 1, 2, 0);
      send(bscs_pkg::OP_CLEAR, 1, 0, 0, 0);
      send(bscs_pkg::OP_PIXEL, 0, 0, 0, 77);
      send(bscs_pkg::OP_PIXEL, 0, 1, 2, 3);
      set_clip(8'd40, 8'd200);
      send(bscs_pkg::OP_PIXEL, 0, 0, 0, 0);
      send(bscs_pkg::OP_PIXEL, 0, 0, 0, 40);
      send(bscs_pkg::OP_PIXEL, 0, 0, 0, 120);
      send(bscs_pkg::OP_PIXEL, 0, 0, 0, 255);

      // random part over several clip settings
      set_clip(8'd0, 8'd255);
      random_frames(100);
      set_clip(8'd200, 8'd100);
      random_frames(80);
      set_clip(8'd255, 8'd255);
      random_frames(60);
      set_clip(8'd0, 8'd0);
      random_frames(60);
      set_clip(8'd30, 8'd31);
      random_frames(60);
      set_clip(8'd60, 8'd180);
      random_frames(100);
      set_clip(8'd0, 8'd255);
      random_frames(60);

      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0) $display("PASS background_subtract_contrast_stretch");
      else $display("FAIL background_subtract_contrast_stretch");
      $finish;
   end

endmodule
